// ----- rtl/i2c_bl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2c_bl_pkg;

	// Request codes
	localparam logic [2:0] REQ_NONE  = 3'd0;
	localparam logic [2:0] REQ_START = 3'd1;
	localparam logic [2:0] REQ_STOP  = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BUS_BUSY = 2'd1;
	localparam logic [1:0] STAT_NO_ACK   = 2'd2;

	// Polls of SDA for an ack before the final deciding sample
	localparam logic [3:0] ACK_POLLS = 4'd10;

	// Delay unit length after reset
	localparam logic [7:0] HALF_PERIOD_RST = 8'd30;

	// One bus tick as it enters the sequencer
	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] wr_byte;
		logic       ack_to_send;
		logic       sda_in;
		logic       scl_in;
	} item_t;

	// Pin drives and status for one tick
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] rd_byte;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_bl_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one bus tick per transaction
interface i2c_bl_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] wr_byte;
	logic       ack_to_send;
	logic       sda_in;
	logic       scl_in;

	modport source (output valid, output req_type, output wr_byte, output ack_to_send,
		output sda_in, output scl_in, input ready);
	modport sink (input valid, input req_type, input wr_byte, input ack_to_send,
		input sda_in, input scl_in, output ready);
endinterface

// Result channel: pin drives and status per transaction
interface i2c_bl_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] rd_byte;

	modport source (output valid, output scl_out, output sda_out, output busy_res,
		output done_res, output status, output rd_byte, input ready);
	modport sink (input valid, input scl_out, input sda_out, input busy_res,
		input done_res, input status, input rd_byte, output ready);
endinterface

// Configuration write channel: half_period
interface i2c_bl_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/i2c_bl_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2c_bl_seq
	import i2c_bl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire item_t      item,
	input  wire logic [7:0] half_period,
	output result_t         res
);

	// Sequencer phases
	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_ST_REL   = 5'd1;
	localparam logic [4:0] PH_ST_CHK   = 5'd2;
	localparam logic [4:0] PH_ST_CLK   = 5'd3;
	localparam logic [4:0] PH_SP_LOW   = 5'd4;
	localparam logic [4:0] PH_SP_CLK   = 5'd5;
	localparam logic [4:0] PH_SP_DAT   = 5'd6;
	localparam logic [4:0] PH_SP_HOLD  = 5'd7;
	localparam logic [4:0] PH_WR_BIT   = 5'd8;
	localparam logic [4:0] PH_WR_HI    = 5'd9;
	localparam logic [4:0] PH_WR_REL   = 5'd10;
	localparam logic [4:0] PH_WR_POLL  = 5'd11;
	localparam logic [4:0] PH_WR_ACKHI = 5'd12;
	localparam logic [4:0] PH_WR_ACKLO = 5'd13;
	localparam logic [4:0] PH_RD_OPEN  = 5'd14;
	localparam logic [4:0] PH_RD_SAMP  = 5'd15;
	localparam logic [4:0] PH_RD_ACK   = 5'd16;
	localparam logic [4:0] PH_RD_CLKHI = 5'd17;
	localparam logic [4:0] PH_RD_CLKLO = 5'd18;
	localparam logic [4:0] PH_ST_DONE  = 5'd19;
	localparam logic [4:0] PH_SP_DONE  = 5'd20;
	localparam logic [4:0] PH_WR_DONE  = 5'd21;
	localparam logic [4:0] PH_RD_DONE  = 5'd22;
	localparam logic [4:0] PH_ST_FAIL  = 5'd23;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	logic [4:0] phase_q, phase_d;
	logic [7:0] tick_q, tick_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [3:0] poll_q, poll_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       ack_q, ack_d;
	logic       rack_q, rack_d;
	logic [8:0] limit;

	// Zero length counts as 256 ticks
	assign limit = (half_period == 8'd0) ? 9'd256 : {1'b0, half_period};

	// Advance the sequencer by one tick
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		poll_d  = poll_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		rack_d  = rack_q;
		res.busy_res = 1'b0;
		res.done_res = 1'b0;
		res.status   = STAT_OK;
		res.rd_byte  = 8'd0;

		// Take a new command only while idle
		if (phase_d == PH_IDLE) begin
			tick_d = 8'd0;
			case (item.req_type)
				REQ_START: phase_d = PH_ST_REL;
				REQ_STOP:  phase_d = PH_SP_LOW;
				REQ_WRITE: begin
					phase_d = PH_WR_BIT;
					shift_d = item.wr_byte;
					bit_d   = 4'd0;
					poll_d  = 4'd0;
					ack_d   = 1'b0;
				end
				REQ_READ: begin
					phase_d = PH_RD_OPEN;
					shift_d = 8'd0;
					bit_d   = 4'd0;
					rack_d  = item.ack_to_send;
				end
				default: ;
			endcase
		end

		if (phase_d != PH_IDLE) begin
			// Apply pin changes and samples on the first tick of a unit
			if (tick_d == 8'd0) begin
				case (phase_d)
					PH_ST_REL: begin
						sda_d = 1'b1;
						scl_d = 1'b1;
					end
					PH_ST_CHK: begin
						if (!item.sda_in || !item.scl_in) phase_d = PH_ST_FAIL;
						else sda_d = 1'b0;
					end
					PH_ST_CLK: scl_d = 1'b0;
					PH_SP_LOW: begin
						scl_d = 1'b0;
						sda_d = 1'b0;
					end
					PH_SP_CLK: scl_d = 1'b1;
					PH_SP_DAT: sda_d = 1'b1;
					PH_WR_BIT: begin
						if (bit_d != 4'd0) scl_d = 1'b0;
						sda_d = shift_d[7];
					end
					PH_WR_HI: begin
						scl_d   = 1'b1;
						shift_d = {shift_d[6:0], 1'b0};
					end
					PH_WR_REL: begin
						scl_d = 1'b0;
						sda_d = 1'b1;
					end
					PH_WR_POLL: begin
						if (!item.sda_in || (poll_d >= ACK_POLLS)) begin
							ack_d   = ~item.sda_in;
							phase_d = PH_WR_ACKHI;
							scl_d   = 1'b1;
						end else begin
							poll_d = poll_d + 4'd1;
						end
					end
					PH_WR_ACKHI: scl_d = 1'b1;
					PH_WR_ACKLO: scl_d = 1'b0;
					PH_RD_OPEN: begin
						sda_d = 1'b1;
						scl_d = 1'b1;
					end
					PH_RD_SAMP: begin
						shift_d = {shift_d[6:0], item.sda_in};
						scl_d   = 1'b0;
						bit_d   = bit_d + 4'd1;
					end
					PH_RD_ACK:   sda_d = ~rack_d;
					PH_RD_CLKHI: scl_d = 1'b1;
					PH_RD_CLKLO: scl_d = 1'b0;
					default: ;
				endcase
			end

			if (phase_d >= PH_ST_DONE) begin
				// Closing tick: report and drop back to idle
				res.done_res = 1'b1;
				if (phase_d == PH_ST_FAIL) begin
					res.status = STAT_BUS_BUSY;
				end else if (phase_d == PH_WR_DONE) begin
					sda_d      = 1'b0;
					res.status = ack_d ? STAT_OK : STAT_NO_ACK;
				end else if (phase_d == PH_RD_DONE) begin
					res.rd_byte = shift_d;
				end
				phase_d = PH_IDLE;
				tick_d  = 8'd0;
			end else begin
				res.busy_res = 1'b1;
				if (({1'b0, tick_d} + 9'd1) >= limit) begin
					// End of unit: move to the next step
					tick_d = 8'd0;
					case (phase_d)
						PH_ST_REL:  phase_d = PH_ST_CHK;
						PH_ST_CHK:  phase_d = PH_ST_CLK;
						PH_ST_CLK:  phase_d = PH_ST_DONE;
						PH_SP_LOW:  phase_d = PH_SP_CLK;
						PH_SP_CLK:  phase_d = PH_SP_DAT;
						PH_SP_DAT:  phase_d = PH_SP_HOLD;
						PH_SP_HOLD: phase_d = PH_SP_DONE;
						PH_WR_BIT:  phase_d = PH_WR_HI;
						PH_WR_HI: begin
							bit_d   = bit_d + 4'd1;
							phase_d = (bit_d < BITS_PER_BYTE) ? PH_WR_BIT : PH_WR_REL;
						end
						PH_WR_REL:   phase_d = PH_WR_POLL;
						PH_WR_POLL:  phase_d = PH_WR_POLL;
						PH_WR_ACKHI: phase_d = PH_WR_ACKLO;
						PH_WR_ACKLO: phase_d = PH_WR_DONE;
						PH_RD_OPEN:  phase_d = PH_RD_SAMP;
						PH_RD_SAMP: begin
							phase_d = (bit_d < BITS_PER_BYTE) ? PH_RD_OPEN : PH_RD_ACK;
						end
						PH_RD_ACK:   phase_d = PH_RD_CLKHI;
						PH_RD_CLKHI: phase_d = PH_RD_CLKLO;
						PH_RD_CLKLO: phase_d = PH_RD_DONE;
						default:     phase_d = PH_IDLE;
					endcase
				end else begin
					tick_d = tick_d + 8'd1;
				end
			end
		end

		res.scl_out = scl_d;
		res.sda_out = sda_d;
	end

	// Hold state between ticks, advance on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= 8'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			poll_q  <= 4'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			rack_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			poll_q  <= poll_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
			rack_q  <= rack_d;
		end
	end

`ifndef SYNTHESIS
	a_close_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |=> (phase_q == PH_IDLE))
		else $error("closing tick did not return to idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit counter past one byte");

	a_poll_range: assert property (@(posedge clk) disable iff (!arst_n)
		poll_q <= ACK_POLLS)
		else $error("ack poll counter past limit");

	a_write_load: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (phase_q == PH_IDLE) && (item.req_type == REQ_WRITE))
		|=> (shift_q == $past(item.wr_byte)))
		else $error("write byte not loaded");
`endif

endmodule

`default_nettype wire

// ----- rtl/i2c_bl_obuf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2c_bl_obuf
	import i2c_bl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire result_t in_data,
	i2c_bl_res_if.source res
);

	logic    valid_s2;
	result_t data_s2;

	// Load when empty or when the held result leaves
	assign in_ready = !valid_s2 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= in_data;
		end
	end

	assign res.valid    = valid_s2;
	assign res.scl_out  = data_s2.scl_out;
	assign res.sda_out  = data_s2.sda_out;
	assign res.busy_res = data_s2.busy_res;
	assign res.done_res = data_s2.done_res;
	assign res.status   = data_s2.status;
	assign res.rd_byte  = data_s2.rd_byte;

endmodule

`default_nettype wire

// ----- rtl/i2c_bit_level_master.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload                                           | Per transaction
// --------+-----+---------------------------------------------------+--------------------
// req     | in  | req_type, wr_byte, ack_to_send, sda_in, scl_in    | one bus tick
// res     | out | scl_out, sda_out, busy_res, done_res, status,     | result of one tick
//         |     | rd_byte                                           |
// cfg     | in  | data (half_period)                                | register write
//
// One tick is accepted every cycle unless req.ready is low; it waits in the input
// register, which feeds the sequencer, whose state updates in a single pass,
// and its result waits in the output register until it is taken.
// A stall on res fills the output register, then the input register, then
// deasserts req.ready. cfg is always ready.
// Reset (arst_n low) returns to idle with both lines released and half_period 30.

module i2c_bit_level_master
	import i2c_bl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	i2c_bl_cfg_if.sink cfg,
	i2c_bl_req_if.sink req,
	i2c_bl_res_if.source res
);

	logic [7:0] half_period_q;
	logic       valid_s1;
	item_t      item_s1;
	logic       ob_ready;
	logic       step;
	result_t    seq_res;

	// Configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
		end else if (cfg.valid) begin
			half_period_q <= cfg.data;
		end
	end

	// Input register: advance when the output register can take a result
	assign step      = valid_s1 && ob_ready;
	assign req.ready = !valid_s1 || ob_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type    <= req.req_type;
			item_s1.wr_byte     <= req.wr_byte;
			item_s1.ack_to_send <= req.ack_to_send;
			item_s1.sda_in      <= req.sda_in;
			item_s1.scl_in      <= req.scl_in;
		end
	end

	i2c_bl_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.half_period (half_period_q),
		.res         (seq_res)
	);

	i2c_bl_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_ready (ob_ready),
		.in_data  (seq_res),
		.res      (res)
	);

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import i2c_bl_pkg::*;

	// Sequencer phases, in the order the closing phases rely on
	typedef enum logic [4:0] {
		SQ_IDLE, SQ_START_REL, SQ_START_CHK, SQ_START_CLK,
		SQ_STOP_LOW, SQ_STOP_CLK, SQ_STOP_DAT, SQ_STOP_HOLD,
		SQ_WR_BIT, SQ_WR_HIGH, SQ_WR_RELEASE, SQ_WR_POLL, SQ_WR_ACK_HI, SQ_WR_ACK_LO,
		SQ_RD_OPEN, SQ_RD_SAMPLE, SQ_RD_ACK, SQ_RD_CLK_HI, SQ_RD_CLK_LO,
		SQ_START_END, SQ_STOP_END, SQ_WR_END, SQ_RD_END, SQ_START_FAIL
	} seq_phase_t;

	typedef struct {
		seq_phase_t phase;
		logic [7:0] ticks;
		logic [3:0] bits;
		logic [7:0] shift;
		logic [3:0] polls;
		logic       scl_drv;
		logic       sda_drv;
		logic       acked;
		logic       give_ack;
	} seq_state_t;

	// How the sensed bus lines behave while one command runs
	typedef enum {LINES_RANDOM, LINES_HIGH, LINES_SDA_LOW, LINES_SCL_LOW, LINES_ACK_AT}
		line_mode_t;

	logic clk;
	logic arst_n;

	i2c_bl_cfg_if cfg_ch();
	i2c_bl_req_if req_ch();
	i2c_bl_res_if res_ch();

	i2c_bit_level_master dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.res    (res_ch)
	);

	item_t      tick_q[$];
	result_t    tick_results_due[$];
	seq_state_t seq_plan;
	seq_state_t seq_live;
	logic [7:0] half_cfg;
	int         ticks_made;
	int         ticks_taken;
	int         fails;
	int         src_idle_pct;
	int         snk_idle_pct;
	bit         calm;
	bit         in_random;
	logic       rx_hold;

	// Advance one sequencer copy by one bus tick and return its pin drives
	function automatic result_t sequencer_tick(inout seq_state_t s, input item_t it,
			input logic [7:0] half);
		result_t    r;
		logic [8:0] span;
		r = '0;
		span = (half == 8'd0) ? 9'd256 : {1'b0, half};
		if (s.phase == SQ_IDLE) begin
			s.ticks = 8'd0;
			case (it.req_type)
				REQ_START: s.phase = SQ_START_REL;
				REQ_STOP:  s.phase = SQ_STOP_LOW;
				REQ_WRITE: begin
					s.phase = SQ_WR_BIT;
					s.shift = it.wr_byte;
					s.bits = 4'd0;
					s.polls = 4'd0;
					s.acked = 1'b0;
				end
				REQ_READ: begin
					s.phase = SQ_RD_OPEN;
					s.shift = 8'd0;
					s.bits = 4'd0;
					s.give_ack = it.ack_to_send;
				end
				default: ;
			endcase
		end
		if (s.phase != SQ_IDLE) begin
			// Pin changes and samples on the first tick of a delay unit
			if (s.ticks == 8'd0) begin
				case (s.phase)
					SQ_START_REL: begin s.sda_drv = 1'b1; s.scl_drv = 1'b1; end
					SQ_START_CHK: begin
						if (!it.sda_in || !it.scl_in) s.phase = SQ_START_FAIL;
						else s.sda_drv = 1'b0;
					end
					SQ_START_CLK: s.scl_drv = 1'b0;
					SQ_STOP_LOW:  begin s.scl_drv = 1'b0; s.sda_drv = 1'b0; end
					SQ_STOP_CLK:  s.scl_drv = 1'b1;
					SQ_STOP_DAT:  s.sda_drv = 1'b1;
					SQ_WR_BIT: begin
						if (s.bits != 4'd0) s.scl_drv = 1'b0;
						s.sda_drv = s.shift[7];
					end
					SQ_WR_HIGH: begin s.scl_drv = 1'b1; s.shift = {s.shift[6:0], 1'b0}; end
					SQ_WR_RELEASE: begin s.scl_drv = 1'b0; s.sda_drv = 1'b1; end
					SQ_WR_POLL: begin
						if (!it.sda_in || s.polls >= ACK_POLLS) begin
							s.acked = !it.sda_in;
							s.phase = SQ_WR_ACK_HI;
							s.scl_drv = 1'b1;
						end else begin
							s.polls = s.polls + 4'd1;
						end
					end
					SQ_WR_ACK_HI: s.scl_drv = 1'b1;
					SQ_WR_ACK_LO: s.scl_drv = 1'b0;
					SQ_RD_OPEN:   begin s.sda_drv = 1'b1; s.scl_drv = 1'b1; end
					SQ_RD_SAMPLE: begin
						s.shift = {s.shift[6:0], it.sda_in};
						s.scl_drv = 1'b0;
						s.bits = s.bits + 4'd1;
					end
					SQ_RD_ACK:    s.sda_drv = !s.give_ack;
					SQ_RD_CLK_HI: s.scl_drv = 1'b1;
					SQ_RD_CLK_LO: s.scl_drv = 1'b0;
					default: ;
				endcase
			end
			if (s.phase >= SQ_START_END) begin
				// Closing tick: report and drop back to idle
				r.done_res = 1'b1;
				case (s.phase)
					SQ_START_FAIL: r.status = STAT_BUS_BUSY;
					SQ_WR_END: begin
						s.sda_drv = 1'b0;
						r.status = s.acked ? STAT_OK : STAT_NO_ACK;
					end
					SQ_RD_END: r.rd_byte = s.shift;
					default: ;
				endcase
				s.phase = SQ_IDLE;
				s.ticks = 8'd0;
			end else begin
				r.busy_res = 1'b1;
				if ({1'b0, s.ticks} + 9'd1 >= span) begin
					s.ticks = 8'd0;
					case (s.phase)
						SQ_START_REL:  s.phase = SQ_START_CHK;
						SQ_START_CHK:  s.phase = SQ_START_CLK;
						SQ_START_CLK:  s.phase = SQ_START_END;
						SQ_STOP_LOW:   s.phase = SQ_STOP_CLK;
						SQ_STOP_CLK:   s.phase = SQ_STOP_DAT;
						SQ_STOP_DAT:   s.phase = SQ_STOP_HOLD;
						SQ_STOP_HOLD:  s.phase = SQ_STOP_END;
						SQ_WR_BIT:     s.phase = SQ_WR_HIGH;
						SQ_WR_HIGH: begin
							s.bits = s.bits + 4'd1;
							s.phase = (s.bits < 4'd8) ? SQ_WR_BIT : SQ_WR_RELEASE;
						end
						SQ_WR_RELEASE: s.phase = SQ_WR_POLL;
						SQ_WR_POLL:    s.phase = SQ_WR_POLL;
						SQ_WR_ACK_HI:  s.phase = SQ_WR_ACK_LO;
						SQ_WR_ACK_LO:  s.phase = SQ_WR_END;
						SQ_RD_OPEN:    s.phase = SQ_RD_SAMPLE;
						SQ_RD_SAMPLE:  s.phase = (s.bits < 4'd8) ? SQ_RD_OPEN : SQ_RD_ACK;
						SQ_RD_ACK:     s.phase = SQ_RD_CLK_HI;
						SQ_RD_CLK_HI:  s.phase = SQ_RD_CLK_LO;
						SQ_RD_CLK_LO:  s.phase = SQ_RD_END;
						default:       s.phase = SQ_IDLE;
					endcase
				end else begin
					s.ticks = s.ticks + 8'd1;
				end
			end
		end
		r.scl_out = s.scl_drv;
		r.sda_out = s.sda_drv;
		return r;
	endfunction

	function automatic seq_state_t seq_reset();
		seq_state_t s;
		s.phase = SQ_IDLE;
		s.ticks = 8'd0;
		s.bits = 4'd0;
		s.shift = 8'd0;
		s.polls = 4'd0;
		s.scl_drv = 1'b1;
		s.sda_drv = 1'b1;
		s.acked = 1'b0;
		s.give_ack = 1'b0;
		return s;
	endfunction

	function automatic void match(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// Queue one command and its ticks until its closing tick or max_ticks
	task automatic issue(input logic [2:0] code, input logic [7:0] data, input logic ack,
			input line_mode_t mode, input int ack_at, input int max_ticks);
		item_t it;
		int    k;
		bit    closed;
		k = 0;
		closed = 1'b0;
		while (!closed) begin
			it.wr_byte = (k == 0) ? data : 8'($urandom);
			it.ack_to_send = (k == 0) ? ack : 1'($urandom);
			if (k == 0) it.req_type = code;
			else if ($urandom_range(0, 3) != 0) it.req_type = REQ_NONE;
			else it.req_type = 3'($urandom_range(1, 7));
			case (mode)
				LINES_HIGH:    begin it.sda_in = 1'b1; it.scl_in = 1'b1; end
				LINES_SDA_LOW: begin it.sda_in = 1'b0; it.scl_in = 1'b1; end
				LINES_SCL_LOW: begin it.sda_in = 1'b1; it.scl_in = 1'b0; end
				LINES_ACK_AT:  begin it.sda_in = (k < ack_at); it.scl_in = 1'b1; end
				default:       begin it.sda_in = 1'($urandom); it.scl_in = 1'($urandom); end
			endcase
			void'(sequencer_tick(seq_plan, it, half_cfg));
			tick_q.push_back(it);
			ticks_made++;
			k++;
			closed = (seq_plan.phase == SQ_IDLE) || (max_ticks != 0 && k >= max_ticks);
		end
	endtask

	// Wait until every queued tick is taken and every result checked
	task automatic settle();
		while (!(ticks_taken == ticks_made && tick_results_due.size() == 0))
			@(posedge clk);
	endtask

	task automatic set_half(input logic [7:0] v);
		settle();
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		half_cfg = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer queued ticks, predict each accepted one
	always @(posedge clk) begin : drive_ticks
		item_t taken;
		item_t nxt;
		bit    offering;
		int    src_gap;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			src_gap = 0;
		end else begin
			offering = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				taken.req_type = req_ch.req_type;
				taken.wr_byte = req_ch.wr_byte;
				taken.ack_to_send = req_ch.ack_to_send;
				taken.sda_in = req_ch.sda_in;
				taken.scl_in = req_ch.scl_in;
				tick_results_due.push_back(sequencer_tick(seq_live, taken, half_cfg));
				ticks_taken++;
				offering = 1'b0;
				if (!calm && $urandom_range(0, 99) < src_idle_pct)
					src_gap = $urandom_range(1, 7);
			end
			if (!offering) begin
				if (src_gap > 0) begin
					src_gap--;
					req_ch.valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					nxt = tick_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= nxt.req_type;
					req_ch.wr_byte <= nxt.wr_byte;
					req_ch.ack_to_send <= nxt.ack_to_send;
					req_ch.sda_in <= nxt.sda_in;
					req_ch.scl_in <= nxt.scl_in;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		int      snk_gap;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (tick_results_due.size() == 0) begin
					$error("result transaction with no tick pending");
					fails++;
				end else begin
					want = tick_results_due.pop_front();
					match("scl_out", want.scl_out, res_ch.scl_out);
					match("sda_out", want.sda_out, res_ch.sda_out);
					match("busy_res", want.busy_res, res_ch.busy_res);
					match("done_res", want.done_res, res_ch.done_res);
					match("status", want.status, res_ch.status);
					match("rd_byte", want.rd_byte, res_ch.rd_byte);
				end
			end
			if (rx_hold) begin
				res_ch.ready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				res_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < snk_idle_pct) begin
				snk_gap = $urandom_range(0, 6);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Hold off results once while a backlog of ticks is waiting
	initial begin
		rx_hold = 1'b0;
		do @(posedge clk); while (!(in_random && tick_q.size() > 20));
		rx_hold <= 1'b1;
		repeat (150) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : stimulus
		int         directed_ticks;
		int         pick;
		int         hp;
		int         ack_at;
		logic [2:0] code;
		line_mode_t mode;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_NONE;
		req_ch.wr_byte = 8'd0;
		req_ch.ack_to_send = 1'b0;
		req_ch.sda_in = 1'b1;
		req_ch.scl_in = 1'b1;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 8'd0;
		seq_plan = seq_reset();
		seq_live = seq_reset();
		half_cfg = HALF_PERIOD_RST;
		ticks_made = 0;
		ticks_taken = 0;
		fails = 0;
		src_idle_pct = 25;
		snk_idle_pct = 25;
		calm = 1'b0;
		in_random = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start at the length that reset leaves, failing after one unit
		issue(REQ_START, 8'h00, 1'b0, LINES_SCL_LOW, 0, 0);

		// Shortest unit: unknown codes, every command, both start failures
		set_half(8'd1);
		issue(3'd5, 8'h00, 1'b0, LINES_RANDOM, 0, 0);
		issue(3'd6, 8'hFF, 1'b1, LINES_RANDOM, 0, 0);
		issue(3'd7, 8'h55, 1'b0, LINES_RANDOM, 0, 0);
		issue(REQ_NONE, 8'hAA, 1'b1, LINES_RANDOM, 0, 0);
		issue(REQ_START, 8'h00, 1'b0, LINES_HIGH, 0, 0);
		issue(REQ_START, 8'h00, 1'b0, LINES_SDA_LOW, 0, 0);
		issue(REQ_START, 8'h00, 1'b0, LINES_SCL_LOW, 0, 0);
		issue(REQ_STOP, 8'h00, 1'b0, LINES_RANDOM, 0, 0);
		issue(REQ_WRITE, 8'hFF, 1'b0, LINES_ACK_AT, 0, 0);
		issue(REQ_WRITE, 8'h00, 1'b1, LINES_ACK_AT, 100000, 0);
		// ack arrives on the tenth poll, then on the deciding sample
		issue(REQ_WRITE, 8'h5A, 1'b0, LINES_ACK_AT, 26, 0);
		issue(REQ_WRITE, 8'hA5, 1'b0, LINES_ACK_AT, 27, 0);
		issue(REQ_READ, 8'h00, 1'b1, LINES_RANDOM, 0, 0);
		issue(REQ_READ, 8'h00, 1'b0, LINES_HIGH, 0, 0);
		issue(REQ_READ, 8'hFF, 1'b1, LINES_SDA_LOW, 0, 0);

		// Shorten the unit while a write sits partway into one
		set_half(8'd20);
		issue(REQ_WRITE, 8'h3C, 1'b0, LINES_ACK_AT, 0, 30);
		set_half(8'd3);
		issue(REQ_NONE, 8'h00, 1'b0, LINES_ACK_AT, 0, 0);

		// Longest unit, zero reads as 256: one unit, then the start check fails
		set_half(8'd0);
		issue(REQ_START, 8'h00, 1'b0, LINES_SDA_LOW, 0, 0);
		directed_ticks = ticks_made;

		// Random command streams over short units
		in_random = 1'b1;
		while (ticks_made - directed_ticks < 120) begin
			case ($urandom_range(0, 5))
				0, 1, 2: hp = 1;
				3:       hp = 2;
				default: hp = $urandom_range(3, 4);
			endcase
			set_half(8'(hp));
			case ($urandom_range(0, 2))
				0:       src_idle_pct = 0;
				1:       src_idle_pct = 15;
				default: src_idle_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0:       snk_idle_pct = 0;
				1:       snk_idle_pct = 15;
				default: snk_idle_pct = 40;
			endcase
			repeat ($urandom_range(3, 6)) begin
				pick = $urandom_range(0, 99);
				mode = LINES_RANDOM;
				ack_at = 0;
				if (pick < 20) begin
					code = REQ_START;
					case ($urandom_range(0, 9))
						0:       mode = LINES_SDA_LOW;
						1:       mode = LINES_SCL_LOW;
						2:       mode = LINES_RANDOM;
						default: mode = LINES_HIGH;
					endcase
				end else if (pick < 35) begin
					code = REQ_STOP;
				end else if (pick < 70) begin
					code = REQ_WRITE;
					mode = ($urandom_range(0, 9) == 0) ? LINES_RANDOM : LINES_ACK_AT;
					ack_at = ($urandom_range(0, 9) < 3) ? 100000 : $urandom_range(0, 32 * hp);
				end else if (pick < 95) begin
					code = REQ_READ;
				end else begin
					code = 3'($urandom_range(5, 7));
				end
				issue(code, 8'($urandom), 1'($urandom), mode, ack_at, 0);
				repeat ($urandom_range(0, 2))
					issue($urandom_range(0, 1) ? REQ_NONE : 3'($urandom_range(5, 7)),
						8'($urandom), 1'($urandom), LINES_RANDOM, 0, 0);
			end
			// Run the tail with both sides always willing
			if (ticks_made - directed_ticks > 70) calm = 1'b1;
		end

		settle();
		repeat (6) @(posedge clk);
		if (fails == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/i2c_bl_pkg.sv
rtl/i2c_bl_if.sv
rtl/i2c_bl_seq.sv
rtl/i2c_bl_obuf.sv
rtl/i2c_bit_level_master.sv
bench/tb_top.sv
